@@ design/ccs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and BCD helpers for the clock/calendar setter.
// No dependencies; used by ccs_update and clock_calendar_setter.
package ccs_pkg;

    // Item kinds
    localparam logic [2:0] KIND_LOAD   = 3'd0;
    localparam logic [2:0] KIND_SET    = 3'd1;
    localparam logic [2:0] KIND_SELECT = 3'd2;
    localparam logic [2:0] KIND_UP     = 3'd3;
    localparam logic [2:0] KIND_DOWN   = 3'd4;

    // Field select codes
    localparam logic [2:0] FIELD_NONE  = 3'd0;
    localparam logic [2:0] FIELD_HOUR  = 3'd1;
    localparam logic [2:0] FIELD_MIN   = 3'd2;
    localparam logic [2:0] FIELD_DAY   = 3'd3;
    localparam logic [2:0] FIELD_MONTH = 3'd4;
    localparam logic [2:0] FIELD_YEAR  = 3'd5;
    localparam logic [2:0] FIELD_LAST  = 3'd7;

    // Field limits
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] DAY_MAX   = 5'd31;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] rtc_minute_bcd;
        logic [7:0] rtc_hour_bcd;
        logic [7:0] rtc_day_bcd;
        logic [7:0] rtc_month_bcd;
        logic [7:0] rtc_year_bcd;
    } t_in_item;

    typedef struct packed {
        logic       editing;
        logic [2:0] field_select;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [5:0] hour_bcd;
        logic [6:0] minute_bcd;
        logic [5:0] day_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
    } t_out_item;

    typedef struct packed {
        logic       edit_flag;
        logic [2:0] selected_field;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_state;

    // Packed BCD pair to binary, hi*10+lo (up to 165)
    function automatic logic [7:0] bcd_decode(input logic [7:0] v);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, v[7:4]};
        lo = {4'd0, v[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // Binary (0..99) to packed BCD; quotient by 10 via 205/2048 reciprocal
    function automatic logic [7:0] bcd_encode(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  quo;
        logic [6:0]  rem;
        prod = {8'd0, v} * 15'd205;
        quo  = prod[14:11];
        rem  = v - ({3'd0, quo} * 7'd10);
        return {quo, rem[3:0]};
    endfunction

endpackage

@@ design/ccs_update.sv @@
`timescale 1ns / 1ps
// Next-state logic for one transaction: load, mode, select and field adjust.
// Depends on ccs_pkg.
module ccs_update
    import ccs_pkg::*;
(
    input  t_state   i_state,
    input  t_in_item i_item,
    output t_state   o_state
);

    logic [7:0] dec_minute;
    logic [7:0] dec_hour;
    logic [7:0] dec_day;
    logic [7:0] dec_month;
    logic [7:0] dec_year;
    logic [4:0] month_len;
    logic [4:0] day_dec;
    logic [2:0] sel_inc;
    logic       do_adjust;
    logic       adj_up;
    t_state     adj;

    // BCD decode of load values
    assign dec_minute = bcd_decode(i_item.rtc_minute_bcd);
    assign dec_hour   = bcd_decode(i_item.rtc_hour_bcd);
    assign dec_day    = bcd_decode(i_item.rtc_day_bcd);
    assign dec_month  = bcd_decode(i_item.rtc_month_bcd);
    assign dec_year   = bcd_decode(i_item.rtc_year_bcd);

    // Days in current month, leap rule on year multiple of 4
    always_comb begin
        unique case (i_state.month)
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            4'd2:    month_len = (i_state.year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: month_len = 5'd31;
        endcase
    end

    assign day_dec = i_state.day - 5'd1;
    assign sel_inc = i_state.selected_field + 3'd1;

    // Field adjust, up or down, with wrap
    always_comb begin
        adj = i_state;
        unique case (i_state.selected_field)
            FIELD_HOUR: begin
                if (adj_up) adj.hour = (i_state.hour >= HOUR_MAX) ? 5'd0 : i_state.hour + 5'd1;
                else        adj.hour = (i_state.hour == 5'd0) ? HOUR_MAX : i_state.hour - 5'd1;
            end
            FIELD_MIN: begin
                if (adj_up) adj.minute = (i_state.minute >= MIN_MAX) ? 6'd0
                                                                      : i_state.minute + 6'd1;
                else        adj.minute = (i_state.minute == 6'd0) ? MIN_MAX
                                                                   : i_state.minute - 6'd1;
            end
            FIELD_DAY: begin
                if (adj_up)                   adj.day = (i_state.day >= month_len) ? 5'd1
                                                                                   : i_state.day + 5'd1;
                else if (i_state.day <= 5'd1) adj.day = month_len;
                else                          adj.day = (day_dec > month_len) ? month_len : day_dec;
            end
            FIELD_MONTH: begin
                if (adj_up) adj.month = (i_state.month >= MONTH_MAX) ? 4'd1
                                                                      : i_state.month + 4'd1;
                else        adj.month = (i_state.month <= 4'd1) ? MONTH_MAX
                                                                 : i_state.month - 4'd1;
            end
            FIELD_YEAR: begin
                if (adj_up) adj.year = (i_state.year >= YEAR_MAX) ? 7'd0 : i_state.year + 7'd1;
                else        adj.year = (i_state.year == 7'd0) ? YEAR_MAX : i_state.year - 7'd1;
            end
            default: ;
        endcase
    end

    // Dispatch on item kind
    always_comb begin
        o_state   = i_state;
        do_adjust = 1'b0;
        adj_up    = 1'b0;
        unique case (i_item.kind)
            KIND_LOAD: begin
                if (!i_state.edit_flag) begin
                    o_state.minute = (dec_minute > {2'd0, MIN_MAX})   ? MIN_MAX   : dec_minute[5:0];
                    o_state.hour   = (dec_hour   > {3'd0, HOUR_MAX})  ? HOUR_MAX  : dec_hour[4:0];
                    o_state.day    = (dec_day    > {3'd0, DAY_MAX})   ? DAY_MAX   : dec_day[4:0];
                    o_state.month  = (dec_month  > {4'd0, MONTH_MAX}) ? MONTH_MAX : dec_month[3:0];
                    o_state.year   = (dec_year   > {1'd0, YEAR_MAX})  ? YEAR_MAX  : dec_year[6:0];
                end
            end
            KIND_SET: begin
                o_state.edit_flag      = !i_state.edit_flag;
                o_state.selected_field = i_state.edit_flag ? FIELD_NONE : FIELD_HOUR;
            end
            KIND_SELECT: begin
                o_state.selected_field = (sel_inc == FIELD_LAST || sel_inc == FIELD_NONE)
                                         ? FIELD_HOUR : sel_inc;
            end
            KIND_UP: begin
                do_adjust = i_state.edit_flag;
                adj_up    = 1'b1;
            end
            KIND_DOWN: begin
                do_adjust = 1'b1;
            end
            default: ;
        endcase
        if (do_adjust) begin
            o_state = adj;
        end
    end

endmodule

@@ design/clock_calendar_setter.sv @@
`timescale 1ns / 1ps
// Clock/calendar setter: input register, update logic, result register.
// The input register feeds the update logic, whose result is registered. Throughput: one
// transaction per cycle while the output is not stalled, set by the state update loop.
// Reset (synchronous, active low) clears mode, selection, all time fields
// and both valid flags. Depends on ccs_pkg and ccs_update.
module clock_calendar_setter
    import ccs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    n_state;
    t_out_item n_out_item;
    logic      adv;

    // Pipeline advances when the result register is free or being drained
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !adv;

    ccs_update u_update (
        .i_state (r_state),
        .i_item  (r_s1_item),
        .o_state (n_state)
    );

    // Result formatting: binary and packed BCD
    always_comb begin
        logic [7:0] bcd_hour;
        logic [7:0] bcd_min;
        logic [7:0] bcd_day;
        logic [7:0] bcd_month;
        logic [7:0] bcd_year;
        bcd_hour  = bcd_encode({2'd0, n_state.hour});
        bcd_min   = bcd_encode({1'd0, n_state.minute});
        bcd_day   = bcd_encode({2'd0, n_state.day});
        bcd_month = bcd_encode({3'd0, n_state.month});
        bcd_year  = bcd_encode(n_state.year);
        n_out_item.editing      = n_state.edit_flag;
        n_out_item.field_select = n_state.selected_field;
        n_out_item.hour         = n_state.hour;
        n_out_item.minute       = n_state.minute;
        n_out_item.day          = n_state.day;
        n_out_item.month        = n_state.month;
        n_out_item.year         = n_state.year;
        n_out_item.hour_bcd     = bcd_hour[5:0];
        n_out_item.minute_bcd   = bcd_min[6:0];
        n_out_item.day_bcd      = bcd_day[5:0];
        n_out_item.month_bcd    = bcd_month[4:0];
        n_out_item.year_bcd     = bcd_year;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_s1_item <= i_in_data;
        end
    end

    // State and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_state <= n_state;
            end
        end
        if (adv && r_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

@@ test/tb_clock_calendar_setter.sv @@
`timescale 1ns / 1ps
// Testbench for clock_calendar_setter: a directed table, then random edit sessions.
// Each result is checked against its table value or an in-bench model of the editor. Needs ccs_pkg and the RTL.
module tb_clock_calendar_setter;
    import ccs_pkg::*;

    // Kinds the block has no use for
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int WORK_ITEMS  = 1300;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AFTER  = 60;
    localparam int DRAIN_WAIT  = 10;
    localparam int LIMIT_NS    = 500000;
    localparam int PLAN_LEN    = 26;

    localparam t_out_item RES_CLEAR = '0;
    localparam t_out_item RES_TOP   = {1'b0, FIELD_NONE, 5'd23, 6'd59, 5'd31, 4'd12, 7'd99,
                                       6'h23, 7'h59, 6'h31, 5'h12, 8'h99};

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item result;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_state    clock_now = '0;
    t_out_item readout_q[$];
    int        errors        = 0;
    int        readouts_seen = 0;
    int        tx_run_left   = 0;
    bit        tx_run_busy   = 1'b0;
    int        rx_run_left   = 0;
    bit        rx_run_busy   = 1'b0;

    // Directed table: reset state, BCD extremes, every kind, wraps and a leap February
    t_plan_row plan [PLAN_LEN] = '{
        {KIND_DOWN,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, RES_CLEAR},
        {KIND_LOAD,     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, RES_TOP},
        {KIND_LOAD,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, RES_CLEAR},
        {KIND_LOAD,     8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 1'b1, RES_TOP},
        {KIND_LOAD,     8'h30, 8'h12, 8'h29, 8'h02, 8'h24, 1'b0, RES_CLEAR},
        {KIND_SPARE_LO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, RES_CLEAR},
        {KIND_SPARE_HI, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_UP,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_DOWN,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SET,      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_LOAD,     8'h45, 8'h07, 8'h15, 8'h06, 8'h50, 1'b0, RES_CLEAR},
        {KIND_UP,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_DOWN,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_UP,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_DOWN,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_DOWN,     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_UP,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_UP,       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SELECT,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR},
        {KIND_SET,      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, RES_CLEAR}
    };

    clock_calendar_setter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] to_bcd(input int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Digit pair as hi*10+lo, saturated to the field's top
    function automatic int from_bcd(input logic [7:0] b, input int top);
        int v;
        v = int'(b[7:4]) * 10 + int'(b[3:0]);
        return (v > top) ? top : v;
    endfunction

    function automatic int days_in_month(input int mo, input int yr);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return (yr % 4 == 0) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Up/down on the selected field; hour, minute, year bottom out at 0, day and month at 1
    function automatic void nudge_field(input bit up);
        int v;
        int top;
        int lo;
        lo = 0;
        case (clock_now.selected_field)
            FIELD_HOUR:  begin v = int'(clock_now.hour);   top = int'(HOUR_MAX); end
            FIELD_MIN:   begin v = int'(clock_now.minute); top = int'(MIN_MAX); end
            FIELD_YEAR:  begin v = int'(clock_now.year);   top = int'(YEAR_MAX); end
            FIELD_MONTH: begin v = int'(clock_now.month);  top = int'(MONTH_MAX); lo = 1; end
            FIELD_DAY: begin
                v   = int'(clock_now.day);
                top = days_in_month(int'(clock_now.month), int'(clock_now.year));
                lo  = 1;
            end
            default: return;
        endcase
        if (up) begin
            v = (v >= top) ? lo : v + 1;
        end else begin
            v = (v <= lo) ? top : v - 1;
            // day left above a shorter month is clamped
            if (v > top) v = top;
        end
        case (clock_now.selected_field)
            FIELD_HOUR:  clock_now.hour   = 5'(v);
            FIELD_MIN:   clock_now.minute = 6'(v);
            FIELD_DAY:   clock_now.day    = 5'(v);
            FIELD_MONTH: clock_now.month  = 4'(v);
            default:     clock_now.year   = 7'(v);
        endcase
    endfunction

    // Apply one transaction to the clock state and return the expected readout
    function automatic t_out_item advance_clock(input t_in_item it);
        t_out_item r;
        case (it.kind)
            KIND_LOAD: begin
                if (!clock_now.edit_flag) begin
                    clock_now.minute = 6'(from_bcd(it.rtc_minute_bcd, int'(MIN_MAX)));
                    clock_now.hour   = 5'(from_bcd(it.rtc_hour_bcd, int'(HOUR_MAX)));
                    clock_now.day    = 5'(from_bcd(it.rtc_day_bcd, int'(DAY_MAX)));
                    clock_now.month  = 4'(from_bcd(it.rtc_month_bcd, int'(MONTH_MAX)));
                    clock_now.year   = 7'(from_bcd(it.rtc_year_bcd, int'(YEAR_MAX)));
                end
            end
            KIND_SET: begin
                clock_now.edit_flag      = !clock_now.edit_flag;
                clock_now.selected_field = clock_now.edit_flag ? FIELD_HOUR : FIELD_NONE;
            end
            KIND_SELECT: begin
                clock_now.selected_field = clock_now.selected_field + 3'd1;
                if (clock_now.selected_field == FIELD_LAST ||
                    clock_now.selected_field == FIELD_NONE)
                    clock_now.selected_field = FIELD_HOUR;
            end
            KIND_UP:   if (clock_now.edit_flag) nudge_field(1'b1);
            KIND_DOWN: nudge_field(1'b0);
            default: ;
        endcase
        r.editing      = clock_now.edit_flag;
        r.field_select = clock_now.selected_field;
        r.hour         = clock_now.hour;
        r.minute       = clock_now.minute;
        r.day          = clock_now.day;
        r.month        = clock_now.month;
        r.year         = clock_now.year;
        r.hour_bcd     = 6'(to_bcd(int'(clock_now.hour)));
        r.minute_bcd   = 7'(to_bcd(int'(clock_now.minute)));
        r.day_bcd      = 6'(to_bcd(int'(clock_now.day)));
        r.month_bcd    = 5'(to_bcd(int'(clock_now.month)));
        r.year_bcd     = to_bcd(int'(clock_now.year));
        return r;
    endfunction

    // Per-transaction wait, in runs that are either busy, with random waits, or back-to-back
    function automatic int draw_wait(inout int run_left, inout bit run_busy);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            run_busy = ($urandom_range(0, 2) != 0);
        end
        run_left--;
        return run_busy ? int'($urandom_range(0, 10)) : 0;
    endfunction

    // Random payload; most loads carry in-range BCD, the rest raw bytes
    function automatic t_in_item make_item(input logic [2:0] kind);
        t_in_item it;
        it.kind           = kind;
        it.rtc_minute_bcd = 8'($urandom);
        it.rtc_hour_bcd   = 8'($urandom);
        it.rtc_day_bcd    = 8'($urandom);
        it.rtc_month_bcd  = 8'($urandom);
        it.rtc_year_bcd   = 8'($urandom);
        if (kind == KIND_LOAD && $urandom_range(0, 4) != 0) begin
            it.rtc_minute_bcd = to_bcd($urandom_range(0, 59));
            it.rtc_hour_bcd   = to_bcd($urandom_range(0, 23));
            it.rtc_day_bcd    = to_bcd($urandom_range(0, 31));
            it.rtc_month_bcd  = to_bcd($urandom_range(0, 12));
            it.rtc_year_bcd   = to_bcd($urandom_range(0, 99));
        end
        return it;
    endfunction

    function automatic logic [2:0] noise_kind();
        return ($urandom_range(0, 1) != 0) ? KIND_UP
                                           : 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    endfunction

    // Offer one transaction; called and returns on a falling edge
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item model;
        gap = draw_wait(tx_run_left, tx_run_busy);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        model = advance_clock(it);
        readout_q.push_back(typed ? want : model);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result side: compare each accepted transaction with the oldest expectation
    always @(posedge i_clk) begin : check_readout
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            readouts_seen++;
            if (readout_q.size() == 0) begin
                $error("result with no expectation waiting");
                errors++;
            end else begin
                want = readout_q.pop_front();
                check_field("editing", 8'(want.editing), 8'(o_out_data.editing));
                check_field("field_select", 8'(want.field_select),
                            8'(o_out_data.field_select));
                check_field("hour", 8'(want.hour), 8'(o_out_data.hour));
                check_field("minute", 8'(want.minute), 8'(o_out_data.minute));
                check_field("day", 8'(want.day), 8'(o_out_data.day));
                check_field("month", 8'(want.month), 8'(o_out_data.month));
                check_field("year", 8'(want.year), 8'(o_out_data.year));
                check_field("hour_bcd", 8'(want.hour_bcd), 8'(o_out_data.hour_bcd));
                check_field("minute_bcd", 8'(want.minute_bcd), 8'(o_out_data.minute_bcd));
                check_field("day_bcd", 8'(want.day_bcd), 8'(o_out_data.day_bcd));
                check_field("month_bcd", 8'(want.month_bcd), 8'(o_out_data.month_bcd));
                check_field("year_bcd", want.year_bcd, o_out_data.year_bcd);
            end
        end
    end

    // Receiver stalls; one long hold early on to back the block up
    initial begin : readout_stall
        int hold;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = draw_wait(rx_run_left, rx_run_busy);
            if (!held && readouts_seen >= HOLD_AFTER) begin
                hold = HOLD_CYCLES;
                held = 1'b1;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Stimulus: reset, directed table, then edit sessions
    initial begin : stimulus
        int         work;
        int         pick;
        logic [2:0] kind;
        work = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++)
            send_item(plan[i].item, plan[i].typed, plan[i].result);

        // load, enter edit, adjust, leave; some noise and unclosed sessions
        while (work < WORK_ITEMS) begin
            send_item(make_item(KIND_LOAD), 1'b0, RES_CLEAR);
            if ($urandom_range(0, 7) == 0)
                send_item(make_item(noise_kind()), 1'b0, RES_CLEAR);
            send_item(make_item(KIND_SET), 1'b0, RES_CLEAR);
            work += 2;
            repeat ($urandom_range(3, 20)) begin
                pick = $urandom_range(0, 19);
                if (pick < 5)
                    kind = KIND_SELECT;
                else if (pick < 13)
                    kind = KIND_UP;
                else if (pick < 19)
                    kind = KIND_DOWN;
                else
                    kind = ($urandom_range(0, 1) != 0) ? KIND_LOAD : noise_kind();
                send_item(make_item(kind), 1'b0, RES_CLEAR);
                if (pick < 19) work++;
            end
            if ($urandom_range(0, 9) != 0) begin
                send_item(make_item(KIND_SET), 1'b0, RES_CLEAR);
                work++;
            end
        end
        i_in_valid <= 1'b0;

        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
